// ===== rtl/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Local mean threshold package
// Shared constants, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package lmt_pkg;

	// Frame store geometry.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_RADIUS = 8;
	localparam int LINES      = 2 * MAX_RADIUS;
	localparam int HEIGHT_CAP = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LINE_W     = $clog2(LINES);
	localparam int ADDR_W     = LINE_W + COL_W;
	localparam int DEPTH      = LINES * MAX_WIDTH;

	// Field and register widths.
	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int RAD_W   = 4;
	localparam int TOFF_W  = 9;
	localparam int GS_W    = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int SUM_W   = 16;
	localparam int CNT_W   = 9;
	localparam int VAL_W   = 20;
	localparam int NUM_W   = GS_W + VAL_W;
	localparam int QUO_W   = NUM_W - 8;
	localparam int STEP_W  = $clog2(QUO_W);

	// Register reset values.
	localparam logic [DIM_W-1:0] FW_RESET  = 11'd640;
	localparam logic [DIM_W-1:0] FH_RESET  = 11'd480;
	localparam logic [RAD_W-1:0] RAD_RESET = 4'd4;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS       = 3'd2;
	localparam logic [IDX_W-1:0] REG_THRESH_OFF   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAMMA_SLOPE  = 3'd4;

	// Input item kinds.
	localparam logic KIND_PIXEL = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE, S_PROC, S_SOUT, S_CHK1, S_CHK2, S_RD, S_ACC, S_PRD,
		S_PACC, S_EV1, S_EV2, S_EV3, S_DINIT, S_DIV, S_FIN, S_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic write_adv;
		logic emit_small;
		logic chk_load;
		logic setup;
		logic rd_en;
		logic rd_pix;
		logic acc;
		logic pix_load;
		logic ev1;
		logic ev2;
		logic ev3;
		logic div_init;
		logic div_step;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic small_frame;
		logic flush;
		logic ready_ok;
		logic win_last;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/lmt_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one source item per transaction.
// ----------------------------------------------------------------------------
interface lmt_in_if;
	import lmt_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, kind, pixel_in, input ready);
	modport sink (input valid, kind, pixel_in, output ready);
endinterface

// ===== rtl/lmt_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one result pixel per transaction.
// ----------------------------------------------------------------------------
interface lmt_out_if;
	import lmt_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_of_frame;

	modport source (output valid, pixel_out, last_of_frame, input ready);
	modport sink (input valid, pixel_out, last_of_frame, output ready);
endinterface

// ===== rtl/lmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Local mean threshold controller
// Sequences one item at a time through store, window sum, divide and output.
// ----------------------------------------------------------------------------
module lmt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lmt_pkg::stat_t stat,
	output lmt_pkg::cmd_t  cmd
);
	import lmt_pkg::*;

	state_t state_q, state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_PROC;
			S_PROC: begin
				if (stat.small_frame) state_nxt = stat.flush ? S_IDLE : S_SOUT;
				else state_nxt = S_CHK1;
			end
			S_SOUT: if (stat.out_free) state_nxt = S_IDLE;
			S_CHK1: state_nxt = S_CHK2;
			S_CHK2: state_nxt = stat.ready_ok ? S_RD : S_IDLE;
			S_RD: state_nxt = S_ACC;
			S_ACC: state_nxt = stat.win_last ? S_PRD : S_RD;
			S_PRD: state_nxt = S_PACC;
			S_PACC: state_nxt = S_EV1;
			S_EV1: state_nxt = S_EV2;
			S_EV2: state_nxt = S_EV3;
			S_EV3: state_nxt = S_DINIT;
			S_DINIT: state_nxt = S_DIV;
			S_DIV: if (stat.div_done) state_nxt = S_FIN;
			S_FIN: state_nxt = S_OUT;
			S_OUT: if (stat.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_PROC: cmd.write_adv = !stat.small_frame;
			S_SOUT: cmd.emit_small = stat.out_free;
			S_CHK1: cmd.chk_load = 1'b1;
			S_CHK2: cmd.setup = stat.ready_ok;
			S_RD: cmd.rd_en = 1'b1;
			S_ACC: cmd.acc = 1'b1;
			S_PRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_pix = 1'b1;
			end
			S_PACC: cmd.pix_load = 1'b1;
			S_EV1: cmd.ev1 = 1'b1;
			S_EV2: cmd.ev2 = 1'b1;
			S_EV3: cmd.ev3 = 1'b1;
			S_DINIT: cmd.div_init = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_FIN: cmd.fin = 1'b1;
			S_OUT: cmd.emit = stat.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

// ===== rtl/lmt_dp.sv =====
// ----------------------------------------------------------------------------
// Local mean threshold datapath
// Registers, positions, line store, window accumulator, divider and output.
// ----------------------------------------------------------------------------
module lmt_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lmt_pkg::cmd_t               cmd,
	output lmt_pkg::stat_t              stat,
	input  logic                        cfg_we,
	input  logic [lmt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [lmt_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_kind,
	input  logic [lmt_pkg::PIX_W-1:0]   in_pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lmt_pkg::PIX_W-1:0]   out_pixel,
	output logic                        out_last
);
	import lmt_pkg::*;

	// Configuration registers.
	logic [DIM_W-1:0]         fw_q, fh_q;
	logic [RAD_W-1:0]         rad_q;
	logic signed [TOFF_W-1:0] toff_q;
	logic signed [GS_W-1:0]   gs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
			rad_q <= RAD_RESET;
			toff_q <= '0;
			gs_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: fw_q <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[DIM_W-1:0];
				REG_RADIUS: rad_q <= cfg_data[RAD_W-1:0];
				REG_THRESH_OFF: toff_q <= $signed(cfg_data[TOFF_W-1:0]);
				REG_GAMMA_SLOPE: gs_q <= $signed(cfg_data[GS_W-1:0]);
				default: ;
			endcase
		end
	end

	// Effective geometry, saturated to what the store can hold.
	logic [DIM_W-1:0] w, h, wm1, hm1, two_r;
	logic [RAD_W-1:0] r;

	always_comb begin
		w = (fw_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_q;
		h = (fh_q > DIM_W'(HEIGHT_CAP)) ? DIM_W'(HEIGHT_CAP) : fh_q;
		if (rad_q == '0) r = RAD_W'(1);
		else if (rad_q > RAD_W'(MAX_RADIUS)) r = RAD_W'(MAX_RADIUS);
		else r = rad_q;
		wm1 = w - DIM_W'(1);
		hm1 = h - DIM_W'(1);
		two_r = {{(DIM_W-RAD_W-1){1'b0}}, r, 1'b0};
	end

	// Latched input item.
	logic             kind_q;
	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= in_kind;
			pix_q <= in_pixel;
		end
	end

	// Input and output raster positions.
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [DIM_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0] in_col_nxt, out_col_nxt;
	logic [DIM_W-1:0] in_row_nxt, out_row_nxt;
	logic             do_write, small_last, emit_last;

	always_comb begin
		if ({1'b0, in_col_q} + DIM_W'(1) >= w) begin
			in_col_nxt = '0;
			in_row_nxt = in_row_q + DIM_W'(1);
		end else begin
			in_col_nxt = in_col_q + COL_W'(1);
			in_row_nxt = in_row_q;
		end
		if ({1'b0, out_col_q} + DIM_W'(1) >= w) begin
			out_col_nxt = '0;
			out_row_nxt = out_row_q + DIM_W'(1);
		end else begin
			out_col_nxt = out_col_q + COL_W'(1);
			out_row_nxt = out_row_q;
		end
		do_write = cmd.write_adv && (kind_q == KIND_PIXEL) && (in_row_q < h);
		small_last = in_row_nxt >= h;
		emit_last = out_row_nxt >= h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if ((cmd.emit_small && small_last) || (cmd.emit && emit_last)) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.emit_small || do_write) begin
			in_col_q <= in_col_nxt;
			in_row_q <= in_row_nxt;
		end else if (cmd.emit) begin
			out_col_q <= out_col_nxt;
			out_row_q <= out_row_nxt;
		end
	end

	// Readiness check: has the last pixel of the pending output's window arrived.
	logic [2*DIM_W-1:0] prod_got_q, prod_need_q;
	logic [COL_W-1:0]   got_col_q, need_col_q;
	logic [DIM_W:0]     need_row_full, need_col_full;
	logic [DIM_W-1:0]   need_row;
	logic [COL_W-1:0]   need_col;
	logic [2*DIM_W:0]   got_pos, need_pos;

	always_comb begin
		need_row_full = {1'b0, out_row_q} + (DIM_W+1)'(r);
		need_row = (need_row_full > {1'b0, hm1}) ? hm1 : need_row_full[DIM_W-1:0];
		need_col_full = (DIM_W+1)'(out_col_q) + (DIM_W+1)'(r);
		need_col = (need_col_full > {1'b0, wm1}) ? wm1[COL_W-1:0] :
			need_col_full[COL_W-1:0];
		got_pos = (2*DIM_W+1)'(prod_got_q) + (2*DIM_W+1)'(got_col_q);
		need_pos = (2*DIM_W+1)'(prod_need_q) + (2*DIM_W+1)'(need_col_q) +
			(2*DIM_W+1)'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.chk_load) begin
			prod_got_q <= in_row_q * w;
			prod_need_q <= need_row * w;
			got_col_q <= in_col_q;
			need_col_q <= need_col;
		end
	end

	// Window bounds of the pending output pixel.
	logic [COL_W-1:0] ox, oy, c0, c1, r0, r1;
	logic [DIM_W:0]   c1_full, r1_full;
	logic [COL_W-1:0] ox_q, oy_q, c0_q, c1_q, r0_q, r1_q, x_q, y_q;

	always_comb begin
		ox = ({1'b0, out_col_q} > wm1) ? wm1[COL_W-1:0] : out_col_q;
		oy = (out_row_q > hm1) ? hm1[COL_W-1:0] : out_row_q[COL_W-1:0];
		c0 = (ox >= COL_W'(r)) ? ox - COL_W'(r) + COL_W'(1) : COL_W'(1);
		r0 = (oy >= COL_W'(r)) ? oy - COL_W'(r) + COL_W'(1) : COL_W'(1);
		c1_full = (DIM_W+1)'(ox) + (DIM_W+1)'(r);
		r1_full = (DIM_W+1)'(oy) + (DIM_W+1)'(r);
		c1 = (c1_full > {1'b0, wm1}) ? wm1[COL_W-1:0] : c1_full[COL_W-1:0];
		r1 = (r1_full > {1'b0, hm1}) ? hm1[COL_W-1:0] : r1_full[COL_W-1:0];
	end

	// Line store: ring of lines indexed by row modulo the line count.
	logic [PIX_W-1:0]  mem [DEPTH];
	logic [PIX_W-1:0]  rd_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	assign wr_addr = {in_row_q[LINE_W-1:0], in_col_q};
	assign rd_addr = cmd.rd_pix ? {oy_q[LINE_W-1:0], ox_q} : {y_q[LINE_W-1:0], x_q};

	always_ff @(posedge clk) begin
		if (do_write) mem[wr_addr] <= pix_q;
		if (cmd.rd_en) rd_q <= mem[rd_addr];
	end

	// Window walk and sum.
	logic [SUM_W-1:0] sum_q;
	logic             win_last;

	assign win_last = (x_q == c1_q) && (y_q == r1_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			ox_q <= ox;
			oy_q <= oy;
			c0_q <= c0;
			c1_q <= c1;
			r0_q <= r0;
			r1_q <= r1;
			x_q <= c0;
			y_q <= r0;
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SUM_W'(rd_q);
			if (x_q == c1_q) begin
				x_q <= c0_q;
				y_q <= y_q + COL_W'(1);
			end else begin
				x_q <= x_q + COL_W'(1);
			end
		end
	end

	// Threshold arithmetic.
	logic [PIX_W-1:0]        p_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [4:0]              cw, rh;
	logic [2*RAD_W+1:0]      rr4;
	logic signed [VAL_W-1:0] t_q, pc_q, diff_q;
	logic                    bin_q;
	logic signed [NUM_W-1:0] num_q;

	always_comb begin
		cw = 5'(c1_q - c0_q) + 5'd1;
		rh = 5'(r1_q - r0_q) + 5'd1;
		rr4 = {(2*RAD_W)'(r * r), 2'b00};
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_load) begin
			p_q <= rd_q;
			cnt_q <= CNT_W'(cw * rh);
		end
		if (cmd.ev1) begin
			t_q <= $signed(VAL_W'(sum_q)) +
				VAL_W'(toff_q * $signed({1'b0, rr4}));
			pc_q <= $signed(VAL_W'(p_q * cnt_q));
		end
		if (cmd.ev2) begin
			diff_q <= pc_q - t_q;
			bin_q <= pc_q > t_q;
		end
		if (cmd.ev3) num_q <= gs_q * diff_q;
	end

	// Restoring divider: floor of (num / 256) by the window count.
	logic signed [QUO_W-1:0] n8;
	logic [QUO_W-1:0]        dvd_q;
	logic [CNT_W-2:0]        rem_q;
	logic [CNT_W-1:0]        trial;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;
	logic                    div_done;

	always_comb begin
		n8 = num_q[NUM_W-1:8];
		trial = {rem_q, dvd_q[QUO_W-1]};
		div_done = step_q == STEP_W'(QUO_W - 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= n8 < 0;
			dvd_q <= (n8 < 0) ? QUO_W'(-n8) : QUO_W'(n8);
			rem_q <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
			if (trial >= cnt_q) begin
				rem_q <= (CNT_W-1)'(trial - cnt_q);
				dvd_q <= {dvd_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-2:0];
				dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	// Result mapping and clipping.
	logic signed [QUO_W+1:0] quo, v;
	logic [PIX_W-1:0]        res, res_q;

	always_comb begin
		quo = $signed({2'b00, dvd_q});
		if (neg_q) quo = -quo - ((rem_q != '0) ? (QUO_W+2)'(1) : (QUO_W+2)'(0));
		v = quo + (QUO_W+2)'(128);
		if (gs_q == '0) res = bin_q ? 8'hFF : 8'h00;
		else if (v < 0) res = 8'h00;
		else if (v > (QUO_W+2)'(255)) res = 8'hFF;
		else res = v[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) res_q <= res;
	end

	// Output register.
	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.emit_small) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pix_q <= res_q;
			out_last_q <= emit_last;
		end else if (cmd.emit_small) begin
			out_pix_q <= '0;
			out_last_q <= small_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pix_q;
	assign out_last = out_last_q;

	// Status to the controller.
	always_comb begin
		stat.small_frame = (w <= two_r) || (h <= two_r);
		stat.flush = kind_q != KIND_PIXEL;
		stat.ready_ok = (in_row_q >= h) || (got_pos >= need_pos);
		stat.win_last = win_last;
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || out_ready;
	end
endmodule

// ===== rtl/local_mean_threshold.sv =====
// An item that releases an output reads its window of N pixels (up to 256) from the line
// store one pixel at a time, and takes its quotient from a 28-step restoring divider. One
// item is in work at a time. arst_n clears positions, the output valid flag and the
// registers to their reset values; the line store is not cleared.
// ----------------------------------------------------------------------------
// Local mean threshold
// Streams one 8-bit channel and thresholds or grades each pixel against its local mean.
// ----------------------------------------------------------------------------
module local_mean_threshold (
	input  logic                      clk,
	input  logic                      arst_n,
	lmt_in_if.sink                    in_ch,
	lmt_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [lmt_pkg::IDX_W-1:0] cfg_index,
	input  logic [lmt_pkg::CFG_W-1:0] cfg_data
);
	import lmt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	lmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	lmt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (in_ch.kind),
		.in_pixel  (in_ch.pixel_in),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_pixel (out_ch.pixel_out),
		.out_last  (out_ch.last_of_frame)
	);

	// A result is only loaded when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_small) |-> (!out_ch.valid || out_ch.ready))
		else $error("result loaded over a pending output transaction");

	// At most one item-level action per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.write_adv, cmd.emit, cmd.emit_small}))
		else $error("conflicting controller commands");

	// A new item is taken only when the previous one has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted back to back while work is pending");
endmodule
